@@ rtl/core/emaf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package emaf_pkg;

  localparam int WARMUP_SAMPLES_DEF = 1;
  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int FRACTION_BITS_DEF  = 8;

  localparam int ATAN_LEN = 24;
  localparam int IDX_W    = 5;
  localparam int CORDIC_W = 36;
  localparam int DIV_W    = 20;
  localparam int IN_FRAC  = 8;

  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [31:0] K_Q30      = 32'd652032874;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [28:0] OUT_MAX    = 29'h1FFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_CLOCKWISE = 2'd0;
  localparam logic [1:0] CFG_UNIT      = 2'd1;
  localparam logic [1:0] CFG_GAIN      = 2'd2;

  // unit codes
  localparam logic [3:0] UNIT_RAW    = 4'd1;
  localparam logic [3:0] UNIT_TURN   = 4'd2;
  localparam logic [3:0] UNIT_DEG    = 4'd3;
  localparam logic [3:0] UNIT_RAD    = 4'd4;
  localparam logic [3:0] UNIT_GRAD   = 4'd5;
  localparam logic [3:0] UNIT_ARCMIN = 4'd6;
  localparam logic [3:0] UNIT_ARCSEC = 4'd7;
  localparam logic [3:0] UNIT_MIL_N  = 4'd8;
  localparam logic [3:0] UNIT_MIL_S  = 4'd9;
  localparam logic [3:0] UNIT_MIL_R  = 4'd10;

  typedef enum logic {CORDIC_ROT, CORDIC_VEC} cordic_mode_t;

  typedef struct packed {
    logic                        start;
    cordic_mode_t                mode;
    logic signed [CORDIC_W-1:0]  x;
    logic signed [CORDIC_W-1:0]  y;
    logic [31:0]                 z;
  } cordic_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SC_GO, S_SC_RUN, S_SC_POST,
    S_DVS_GO, S_DVS_RUN, S_DVC_GO, S_DVC_RUN,
    S_EMS_MUL, S_EMS_ADD, S_EMC_MUL, S_EMC_ADD,
    S_AT_GO, S_AT_RUN, S_AT_POST,
    S_UI_MUL, S_UI_RND, S_UA_MUL, S_UA_RND, S_DONE
  } seq_state_t;

  function automatic logic [31:0] unit_factor(input logic [3:0] u);
    logic [31:0] f;
    case (u)
      UNIT_TURN:   f = 32'd1;
      UNIT_DEG:    f = 32'd360;
      UNIT_RAD:    f = TWO_PI_Q29;
      UNIT_GRAD:   f = 32'd400;
      UNIT_ARCMIN: f = 32'd21600;
      UNIT_ARCSEC: f = 32'd1296000;
      UNIT_MIL_N:  f = 32'd6400;
      UNIT_MIL_S:  f = 32'd6300;
      UNIT_MIL_R:  f = 32'd6000;
      default:     f = 32'd16384;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/emaf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface emaf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] angle_high_byte;
  logic [7:0] angle_low_byte;
  modport source (output valid, angle_high_byte, angle_low_byte, input ready);
  modport sink (input valid, angle_high_byte, angle_low_byte, output ready);
endinterface

interface emaf_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] raw_angle;
  logic [28:0] instant_angle;
  logic [28:0] average_angle;
  logic        average_valid;
  modport source (output valid, raw_angle, instant_angle, average_angle, average_valid,
                  input ready);
  modport sink (input valid, raw_angle, instant_angle, average_angle, average_valid,
                output ready);
endinterface

interface emaf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/emaf_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
module emaf_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  emaf_pkg::cordic_cmd_t                 cmd,
  output logic                                  busy,
  output logic signed [emaf_pkg::CORDIC_W-1:0]  x,
  output logic signed [emaf_pkg::CORDIC_W-1:0]  y,
  output logic [31:0]                           z
);
  import emaf_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(CORDIC_STEPS - 1);

  logic                       busy_r;
  logic [IDX_W-1:0]           step_r;
  cordic_mode_t               mode_r;
  logic signed [CORDIC_W-1:0] x_r, y_r;
  logic [31:0]                z_r;
  logic signed [CORDIC_W-1:0] xs, ys;
  logic                       sigma;

  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  // rotate toward zero residual angle, or toward the x axis when vectoring
  assign sigma = (mode_r == CORDIC_ROT) ? ~z_r[31] : y_r[CORDIC_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == LAST) busy_r <= 1'b0;
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= cmd.mode;
      x_r    <= cmd.x;
      y_r    <= cmd.y;
      z_r    <= cmd.z;
    end else if (busy_r) begin
      if (sigma) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ATAN_TURNS[step_r];
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ATAN_TURNS[step_r];
      end
    end
  end

  assign busy = busy_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
endmodule
`default_nettype wire

@@ rtl/core/emaf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module emaf_div #(
  parameter int DIVISOR = 2
) (
  input  wire signed [emaf_pkg::DIV_W-1:0]   num,
  input  wire signed [55:0]                  prod,
  output logic [22:0]                        mag,
  output logic [32:0]                        recip,
  output logic signed [emaf_pkg::DIV_W-1:0]  quot
);
  import emaf_pkg::*;

  // floor(n / DIVISOR) = (n * RECIP) >> RECIP_SH, exact for |n| below 2^19
  localparam int          RECIP_SH = 24;
  localparam logic [32:0] RECIP    = 33'((2**RECIP_SH + DIVISOR - 1) / DIVISOR);

  logic             neg;
  logic [DIV_W-1:0] m, q;

  assign neg = num[DIV_W-1];
  // floor division: a negative numerator takes the ceiling of its magnitude
  assign m     = neg ? (DIV_W'(-num) + DIV_W'(DIVISOR - 1)) : num;
  assign mag   = 23'(m);
  assign recip = RECIP;
  assign q     = prod[RECIP_SH +: DIV_W];
  assign quot  = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

@@ rtl/core/emaf_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
module emaf_mul (
  input  wire                clk,
  input  wire signed [22:0]  a,
  input  wire signed [32:0]  b,
  output logic signed [55:0] p
);
  logic signed [55:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 56'(a) * 56'(b);
  end

  assign p = p_r;
endmodule
`default_nettype wire

@@ rtl/core/circular_ema_angle_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Circular-mean EMA filter for a 14-bit rotary angle.
// in_ch carries the two angle register bytes; out_ch returns the assembled
// angle, the instant angle and the averaged angle in the selected unit, and
// a flag set once warm-up is over and the average was updated by this item.
// cfg_ch writes clockwise (index 0), unit_select (1) and smoothing_gain (2);
// it is always ready and is meant to be written while no item is in flight.
// Writing clockwise also clears the sine/cosine averages and warm-up count.
// One item at a time: in_ch is ready only while the sequencer is idle.
// One shared CORDIC runs the sin/cos rotation and the atan2 vectoring, and one
// shared multiplier does the EMA, the warm-up divides (by reciprocal) and the
// unit scaling. Once warm-up is done an item runs the sin/cos rotation, the
// EMA of sine and cosine, the atan2 vectoring and then the scaling of the
// instant and the averaged angle. Warm-up items skip the EMA and atan2 and
// add the divided sine and cosine to the averages instead.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds the sequencer only at its last step.
// Reset (rst_n low, synchronous) clears all filter state and restores config.
module circular_ema_angle_filter #(
  parameter int WARMUP_SAMPLES = emaf_pkg::WARMUP_SAMPLES_DEF,
  parameter int CORDIC_STEPS   = emaf_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS  = emaf_pkg::FRACTION_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  emaf_in_if.sink      in_ch,
  emaf_out_if.source   out_ch,
  emaf_cfg_if.sink     cfg_ch
);
  import emaf_pkg::*;

  localparam int SH_LIN = 22 - FRACTION_BITS;
  localparam int SH_RAD = 51 - FRACTION_BITS;

  seq_state_t state_r, state_nxt;

  logic        clockwise_r;
  logic [3:0]  unit_r;
  logic [15:0] gain_r;

  logic [13:0]        sample_r;
  logic [1:0]         quad_r;
  logic signed [17:0] sin_r, cos_r, ms_r, mc_r;
  logic [21:0]        mac_r;
  logic [4:0]         wc_r;
  logic               avg_ok_r;
  logic [28:0]        inst_r, avg_r;

  logic        out_valid_r;
  logic [13:0] out_raw_r;
  logic [28:0] out_inst_r, out_avg_r;
  logic        out_ok_r;

  logic        in_acc, cfg_acc, out_free, warm;
  logic [13:0] sample_in;

  cordic_cmd_t                cmd;
  logic                       c_busy;
  logic signed [CORDIC_W-1:0] c_x, c_y;
  logic [31:0]                c_z;

  logic signed [DIV_W-1:0] d_num, d_quot;
  logic [22:0]             d_mag;
  logic [32:0]             d_recip;

  logic signed [22:0] m_a;
  logic signed [32:0] m_b;
  logic signed [55:0] m_p;

  function automatic logic signed [17:0] sat18(input logic signed [40:0] v);
    if (v > 41'sd131071) return 18'sd131071;
    if (v < -41'sd131072) return -18'sd131072;
    return 18'(v);
  endfunction

  function automatic logic signed [17:0] trig_q16(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + CORDIC_W'(8192)) >>> 14;
    if (r > CORDIC_W'(65536)) return 18'sd65536;
    if (r < -CORDIC_W'(65536)) return -18'sd65536;
    return 18'(r);
  endfunction

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cfg_acc   = cfg_ch.valid && cfg_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign warm      = wc_r < 5'(WARMUP_SAMPLES);
  assign sample_in = {in_ch.angle_high_byte, in_ch.angle_low_byte[5:0]};

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  emaf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .busy(c_busy), .x(c_x), .y(c_y), .z(c_z)
  );

  emaf_div #(.DIVISOR(2 * WARMUP_SAMPLES)) u_div (
    .num(d_num), .prod(m_p), .mag(d_mag), .recip(d_recip), .quot(d_quot)
  );

  emaf_mul u_mul (.clk(clk), .a(m_a), .b(m_b), .p(m_p));

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_acc) state_nxt = S_SC_GO;
      S_SC_GO:   state_nxt = S_SC_RUN;
      S_SC_RUN:  if (!c_busy) state_nxt = S_SC_POST;
      S_SC_POST: state_nxt = warm ? S_DVS_GO : S_EMS_MUL;
      S_DVS_GO:  state_nxt = S_DVS_RUN;
      S_DVS_RUN: state_nxt = S_DVC_GO;
      S_DVC_GO:  state_nxt = S_DVC_RUN;
      S_DVC_RUN: state_nxt = S_UI_MUL;
      S_EMS_MUL: state_nxt = S_EMS_ADD;
      S_EMS_ADD: state_nxt = S_EMC_MUL;
      S_EMC_MUL: state_nxt = S_EMC_ADD;
      S_EMC_ADD: state_nxt = S_AT_GO;
      S_AT_GO:   state_nxt = S_AT_RUN;
      S_AT_RUN:  if (!c_busy) state_nxt = S_AT_POST;
      S_AT_POST: state_nxt = S_UI_MUL;
      S_UI_MUL:  state_nxt = S_UI_RND;
      S_UI_RND:  state_nxt = S_UA_MUL;
      S_UA_MUL:  state_nxt = S_UA_RND;
      S_UA_RND:  state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // unit operand commands
  logic [31:0] rot_p, rot_q, rot_d;
  logic signed [CORDIC_W-1:0] vx, vy;

  assign rot_p = {sample_r, 18'b0};
  assign rot_q = rot_p + 32'h2000_0000;
  assign rot_d = rot_p - {rot_q[31:30], 30'b0};
  assign vx    = CORDIC_W'(mc_r) <<< 14;
  assign vy    = CORDIC_W'(ms_r) <<< 14;

  // warm-up numerator 2*s + WARMUP_SAMPLES, cosine while in the cosine divide
  assign d_num = ((state_r == S_DVC_GO || state_r == S_DVC_RUN) ?
                  (DIV_W'(cos_r) <<< 1) : (DIV_W'(sin_r) <<< 1)) + DIV_W'(WARMUP_SAMPLES);

  always_comb begin
    cmd       = '0;
    cmd.mode  = CORDIC_ROT;
    m_a       = '0;
    m_b       = '0;
    unique case (state_r)
      S_SC_GO: begin
        cmd.start = 1'b1;
        cmd.x     = CORDIC_W'(K_Q30);
        cmd.z     = rot_d;
      end
      S_AT_GO: begin
        cmd.start = 1'b1;
        cmd.mode  = CORDIC_VEC;
        // left half plane: flip the vector and start half a turn around
        if (mc_r < 0) begin
          cmd.x = -vx;
          cmd.y = -vy;
          cmd.z = 32'h8000_0000;
        end else begin
          cmd.x = vx;
          cmd.y = vy;
        end
      end
      S_DVS_GO, S_DVC_GO: begin
        m_a = d_mag;
        m_b = d_recip;
      end
      S_EMS_MUL: begin
        m_a = 23'(sin_r) - 23'(ms_r);
        m_b = {17'b0, gain_r};
      end
      S_EMC_MUL: begin
        m_a = 23'(cos_r) - 23'(mc_r);
        m_b = {17'b0, gain_r};
      end
      S_UI_MUL: begin
        m_a = {1'b0, sample_r, 8'b0};
        m_b = {1'b0, unit_factor(unit_r)};
      end
      S_UA_MUL: begin
        m_a = {1'b0, mac_r};
        m_b = {1'b0, unit_factor(unit_r)};
      end
      default: ;
    endcase
  end

  // rounding of the scaled product
  logic [55:0] pu, r_lin, r_rad, r_sel;
  logic [28:0] scaled;
  logic signed [39:0] ema_t;
  logic [32:0] z_rnd;

  assign pu     = m_p;
  assign r_lin  = (pu + (56'(1) << (SH_LIN - 1))) >> SH_LIN;
  assign r_rad  = (pu + (56'(1) << (SH_RAD - 1))) >> SH_RAD;
  assign r_sel  = (unit_r == UNIT_RAD) ? r_rad : r_lin;
  assign scaled = (r_sel > 56'(OUT_MAX)) ? OUT_MAX : r_sel[28:0];
  assign ema_t  = 40'((m_p + 56'sd32768) >>> 16);
  assign z_rnd  = {1'b0, c_z} + 33'd512;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clockwise_r <= 1'b0;
      unit_r      <= UNIT_RAW;
      gain_r      <= 16'd21845;
      ms_r        <= '0;
      mc_r        <= '0;
      mac_r       <= '0;
      wc_r        <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          CFG_CLOCKWISE: begin
            clockwise_r <= cfg_ch.data[0];
            ms_r        <= '0;
            mc_r        <= '0;
            mac_r       <= '0;
            wc_r        <= '0;
          end
          CFG_UNIT: unit_r <= cfg_ch.data[3:0];
          CFG_GAIN: gain_r <= cfg_ch.data;
          default: ;
        endcase
      end
      case (state_r)
        S_DVS_RUN: ms_r <= sat18(41'(ms_r) + 41'(d_quot));
        S_DVC_RUN: begin
          mc_r <= sat18(41'(mc_r) + 41'(d_quot));
          wc_r <= wc_r + 1'b1;
        end
        S_EMS_ADD: ms_r <= sat18(41'(ms_r) + 41'(ema_t));
        S_EMC_ADD: mc_r <= sat18(41'(mc_r) + 41'(ema_t));
        S_AT_POST: mac_r <= (ms_r == 0 && mc_r == 0) ? 22'd0 : z_rnd[31:10];
        default: ;
      endcase
    end
  end

  logic signed [17:0] tc, ts;
  assign tc = trig_q16(c_x);
  assign ts = trig_q16(c_y);

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_acc) begin
        sample_r <= clockwise_r ? (14'h3FFF - sample_in) : sample_in;
        avg_ok_r <= 1'b0;
      end
      S_SC_GO: quad_r <= rot_q[31:30];
      S_SC_POST: begin
        case (quad_r)
          2'd0:    begin cos_r <= tc;  sin_r <= ts;  end
          2'd1:    begin cos_r <= -ts; sin_r <= tc;  end
          2'd2:    begin cos_r <= -tc; sin_r <= -ts; end
          default: begin cos_r <= ts;  sin_r <= -tc; end
        endcase
      end
      S_AT_POST: avg_ok_r <= 1'b1;
      S_UI_RND:  inst_r <= scaled;
      S_UA_RND:  avg_r <= scaled;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_raw_r  <= sample_r;
      out_inst_r <= inst_r;
      out_avg_r  <= avg_r;
      out_ok_r   <= avg_ok_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.raw_angle     = out_raw_r;
  assign out_ch.instant_angle = out_inst_r;
  assign out_ch.average_angle = out_avg_r;
  assign out_ch.average_valid = out_ok_r;
endmodule
`default_nettype wire
